// File: rtl/ffta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffta_pkg
// Shared types and constants for the FIFO full-time accumulator.
// ----------------------------------------------------------------------------
package ffta_pkg;

  // fixed field widths
  localparam int REG_W   = 48;   // window registers and expected_ticks
  localparam int BITS_W  = 6;    // width registers
  localparam int SUM_W   = 64;   // accumulators and tick carrier
  localparam int VAL_W   = 32;   // value carrier, largest value width
  localparam int HALF_W  = 32;   // multiplier operand split
  localparam int APB_DW  = 64;
  localparam int APB_AW  = 5;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // input action codes
  typedef enum logic [1:0] {
    ACT_OCC = 2'd0,
    ACT_CAP = 2'd1,
    ACT_FIN = 2'd2
  } action_t;

  // register indexes (paddr[4:3])
  typedef enum logic [1:0] {
    REG_WIN_START = 2'd0,
    REG_WIN_END   = 2'd1,
    REG_OCC_BITS  = 2'd2,
    REG_CAP_BITS  = 2'd3
  } reg_idx_t;

  // configuration as seen by the front
  typedef struct packed {
    logic [REG_W-1:0]  win_start;
    logic [REG_W-1:0]  win_end;
    logic [BITS_W-1:0] occ_bits;
    logic [BITS_W-1:0] cap_bits;
  } cfg_t;

  // classified record, front to back; finish carries expected ticks in ticks
  typedef struct packed {
    logic             fin;
    logic             full;
    logic [SUM_W-1:0] ticks;
    logic [VAL_W-1:0] occ;
    logic [VAL_W-1:0] cap;
  } rec_t;

  // partial products after the multiplier stage
  typedef struct packed {
    logic             fin;
    logic             full;
    logic [SUM_W-1:0] ticks;
    logic [SUM_W-1:0] occ_lo;
    logic [SUM_W-1:0] occ_hi;
    logic [SUM_W-1:0] cap_lo;
    logic [SUM_W-1:0] cap_hi;
  } prod_t;

  // saturated weights ready to accumulate
  typedef struct packed {
    logic             fin;
    logic             full;
    logic [SUM_W-1:0] ticks;
    logic [SUM_W-1:0] occ_w;
    logic [SUM_W-1:0] cap_w;
  } wtd_t;

  // saturating 64-bit add
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/ffta_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffta_if
// Valid/ready channels for event beats and report beats.
// ----------------------------------------------------------------------------
interface ffta_in_if #(
  parameter int TIME_WIDTH = 48
);
  logic                  valid;
  logic                  ready;
  logic [1:0]            action;
  logic [TIME_WIDTH-1:0] event_time;
  logic [31:0]           sample_value;
  logic                  value_known;

  modport source (output valid, action, event_time, sample_value, value_known,
                  input ready);
  modport sink   (input valid, action, event_time, sample_value, value_known,
                  output ready);
endinterface

interface ffta_out_if;
  logic        valid;
  logic        ready;
  logic [47:0] expected_ticks;
  logic [63:0] known_ticks;
  logic [63:0] full_ticks;
  logic [63:0] occupancy_weighted;
  logic [63:0] capacity_weighted;

  modport source (output valid, expected_ticks, known_ticks, full_ticks,
                  occupancy_weighted, capacity_weighted, input ready);
  modport sink   (input valid, expected_ticks, known_ticks, full_ticks,
                  occupancy_weighted, capacity_weighted, output ready);
endinterface
`default_nettype wire

// File: rtl/ffta_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffta_front
// Tracks held occupancy/capacity and event span; turns each beat into a
// credit record or a finish record for the back end.
// ----------------------------------------------------------------------------
module ffta_front
  import ffta_pkg::*;
#(
  parameter int TIME_WIDTH  = 48,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire cfg_t                  cfg,
  input  wire logic                  in_fire,
  input  wire logic [1:0]            in_action,
  input  wire logic [TIME_WIDTH-1:0] in_time,
  input  wire logic [31:0]           in_value,
  input  wire logic                  in_known,
  output logic                       push,
  output rec_t                       push_rec
);

  logic [VALUE_WIDTH-1:0] occ_r, cap_r;
  logic                   occ_vld_r, cap_vld_r;
  logic                   seen_r;
  logic [TIME_WIDTH-1:0]  first_r, last_r;

  logic [TIME_WIDTH-1:0]  ws, we, lo_ev, hi_ev, lo_fin, hi_fin;
  logic                   is_event, is_fin, credit;
  logic [REG_W-1:0]       expected;
  logic [VALUE_WIDTH-1:0] occ_mask, cap_mask, raw;

  assign ws  = TIME_WIDTH'(cfg.win_start);
  assign we  = TIME_WIDTH'(cfg.win_end);
  assign raw = VALUE_WIDTH'(in_value);

  // width masks; zero width behaves as one, overly wide as full
  always_comb begin
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      occ_mask[i] = (i == 0) || (cfg.occ_bits > BITS_W'(i));
      cap_mask[i] = (i == 0) || (cfg.cap_bits > BITS_W'(i));
    end
  end

  // classify the beat
  always_comb begin
    is_event = in_fire && ((in_action == ACT_OCC) || (in_action == ACT_CAP));
    is_fin   = in_fire && (in_action == ACT_FIN);
  end

  // interval since the previous event, clipped to the window
  always_comb begin
    lo_ev  = (last_r > ws) ? last_r : ws;
    hi_ev  = (in_time < we) ? in_time : we;
    credit = seen_r && (in_time > last_r) && (hi_ev > lo_ev) &&
             occ_vld_r && cap_vld_r && (cap_r != '0);
  end

  // event span clipped to the window
  always_comb begin
    lo_fin   = (ws > first_r) ? ws : first_r;
    hi_fin   = (we < last_r) ? we : last_r;
    expected = (seen_r && (hi_fin > lo_fin)) ? REG_W'(hi_fin - lo_fin) : '0;
  end

  // record to the queue
  always_comb begin
    push          = (is_event && credit) || is_fin;
    push_rec.fin  = is_fin;
    push_rec.full = occ_r >= cap_r;
    push_rec.ticks = is_fin ? SUM_W'(expected) : SUM_W'(hi_ev - lo_ev);
    push_rec.occ  = VAL_W'(occ_r);
    push_rec.cap  = VAL_W'(cap_r);
  end

  // held state
  always_ff @(posedge clk) begin
    if (!rst_n || is_fin) begin
      occ_r     <= '0;
      cap_r     <= '0;
      occ_vld_r <= 1'b0;
      cap_vld_r <= 1'b0;
      seen_r    <= 1'b0;
      first_r   <= '0;
      last_r    <= '0;
    end else if (is_event) begin
      seen_r <= 1'b1;
      if (!seen_r || (in_time < first_r)) first_r <= in_time;
      if (!seen_r || (in_time > last_r))  last_r  <= in_time;
      if (in_action == ACT_OCC) begin
        occ_vld_r <= in_known;
        occ_r     <= in_known ? (raw & occ_mask) : '0;
      end else begin
        cap_vld_r <= in_known;
        cap_r     <= in_known ? (raw & cap_mask) : '0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ffta_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffta_queue
// Short record queue between the front and back ends.
// ----------------------------------------------------------------------------
module ffta_queue
  import ffta_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire rec_t push_rec,
  output logic      not_full,
  output logic      not_empty,
  input  wire logic pop,
  output rec_t      head
);

  rec_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign not_full  = count_r < QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && not_full;
  assign do_pop    = pop && not_empty;
  assign head      = mem_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/ffta_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffta_back
// Multiply, saturate and accumulate credit records; emit totals on finish.
// ----------------------------------------------------------------------------
module ffta_back
  import ffta_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire rec_t        q_head,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [REG_W-1:0] out_expected,
  output logic [SUM_W-1:0] out_known,
  output logic [SUM_W-1:0] out_full,
  output logic [SUM_W-1:0] out_occ_w,
  output logic [SUM_W-1:0] out_cap_w
);

  prod_t             s1_r;
  logic              s1_vld_r;
  wtd_t              s2_r, s2_nxt;
  logic              s2_vld_r;
  logic              adv;
  logic [SUM_W-1:0]  known_r, full_r, occw_r, capw_r;
  logic              out_vld_r;
  logic [REG_W-1:0]  exp_r;
  logic [SUM_W-1:0]  rep_known_r, rep_full_r, rep_occw_r, rep_capw_r;
  logic [SUM_W:0]    occ_sum, cap_sum;
  logic [HALF_W-1:0] t_lo, t_hi;

  // whole pipe holds only while a finish waits on a full report register
  assign adv   = !(s2_vld_r && s2_r.fin && out_vld_r && !out_ready);
  assign q_pop = adv && q_valid;
  assign t_lo  = q_head.ticks[HALF_W-1:0];
  assign t_hi  = q_head.ticks[SUM_W-1:HALF_W];

  // stage 1: four 32x32 partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.fin    <= q_head.fin;
      s1_r.full   <= q_head.full;
      s1_r.ticks  <= q_head.ticks;
      s1_r.occ_lo <= SUM_W'(q_head.occ) * SUM_W'(t_lo);
      s1_r.occ_hi <= SUM_W'(q_head.occ) * SUM_W'(t_hi);
      s1_r.cap_lo <= SUM_W'(q_head.cap) * SUM_W'(t_lo);
      s1_r.cap_hi <= SUM_W'(q_head.cap) * SUM_W'(t_hi);
    end
  end

  // stage 2: combine halves, saturate at all ones
  always_comb begin
    occ_sum = {1'b0, s1_r.occ_hi[HALF_W-1:0], {HALF_W{1'b0}}} + {1'b0, s1_r.occ_lo};
    cap_sum = {1'b0, s1_r.cap_hi[HALF_W-1:0], {HALF_W{1'b0}}} + {1'b0, s1_r.cap_lo};
    s2_nxt.fin   = s1_r.fin;
    s2_nxt.full  = s1_r.full;
    s2_nxt.ticks = s1_r.ticks;
    s2_nxt.occ_w = ((|s1_r.occ_hi[SUM_W-1:HALF_W]) || occ_sum[SUM_W]) ?
                   {SUM_W{1'b1}} : occ_sum[SUM_W-1:0];
    s2_nxt.cap_w = ((|s1_r.cap_hi[SUM_W-1:HALF_W]) || cap_sum[SUM_W]) ?
                   {SUM_W{1'b1}} : cap_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s2_r <= s2_nxt;
  end

  // accumulators; a finish snapshots them and clears
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r <= '0;
      full_r  <= '0;
      occw_r  <= '0;
      capw_r  <= '0;
    end else if (adv && s2_vld_r) begin
      if (s2_r.fin) begin
        known_r <= '0;
        full_r  <= '0;
        occw_r  <= '0;
        capw_r  <= '0;
      end else begin
        known_r <= sat_add(known_r, s2_r.ticks);
        occw_r  <= sat_add(occw_r, s2_r.occ_w);
        capw_r  <= sat_add(capw_r, s2_r.cap_w);
        if (s2_r.full) full_r <= sat_add(full_r, s2_r.ticks);
      end
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && s2_vld_r && s2_r.fin) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_vld_r && s2_r.fin) begin
      exp_r       <= s2_r.ticks[REG_W-1:0];
      rep_known_r <= known_r;
      rep_full_r  <= full_r;
      rep_occw_r  <= occw_r;
      rep_capw_r  <= capw_r;
    end
  end

  assign out_valid    = out_vld_r;
  assign out_expected = exp_r;
  assign out_known    = rep_known_r;
  assign out_full     = rep_full_r;
  assign out_occ_w    = rep_occw_r;
  assign out_cap_w    = rep_capw_r;

endmodule
`default_nettype wire

// File: rtl/fifo_full_time_accumulator_unit.sv
// Path: an accepted finish beat goes through the record queue, the multiplier
// stage and the saturate stage, then accumulate/report loads the output
// register. Throughput: one beat per cycle; the back end stalls only while a
// finish waits behind an unread report, and the front keeps taking beats
// until the 4-entry record queue fills. Reset: synchronous, active low;
// clears all tracked state and totals, loads window and width registers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_full_time_accumulator_unit
// Time-weighted FIFO occupancy monitor with APB register file.
// ----------------------------------------------------------------------------
module fifo_full_time_accumulator_unit
  import ffta_pkg::*;
#(
  parameter int TIME_WIDTH  = 48,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  ffta_in_if.sink                in_ch,
  ffta_out_if.source             out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     wr_en;
  logic     in_fire;
  logic     push, q_not_full, q_not_empty, q_pop;
  rec_t     push_rec, q_head;

  // register file
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.win_start <= '0;
      cfg_r.win_end   <= {REG_W{1'b1}};
      cfg_r.occ_bits  <= BITS_W'(32);
      cfg_r.cap_bits  <= BITS_W'(32);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_WIN_START: cfg_r.win_start <= pwdata[REG_W-1:0];
        REG_WIN_END:   cfg_r.win_end   <= pwdata[REG_W-1:0];
        REG_OCC_BITS:  cfg_r.occ_bits  <= pwdata[BITS_W-1:0];
        REG_CAP_BITS:  cfg_r.cap_bits  <= pwdata[BITS_W-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIN_START: prdata = APB_DW'(cfg_r.win_start);
      REG_WIN_END:   prdata = APB_DW'(cfg_r.win_end);
      REG_OCC_BITS:  prdata = APB_DW'(cfg_r.occ_bits);
      REG_CAP_BITS:  prdata = APB_DW'(cfg_r.cap_bits);
      default:       prdata = '0;
    endcase
  end

  // input beat
  assign in_ch.ready = q_not_full;
  assign in_fire     = in_ch.valid && q_not_full;

  ffta_front #(
    .TIME_WIDTH  (TIME_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_fire   (in_fire),
    .in_action (in_ch.action),
    .in_time   (in_ch.event_time),
    .in_value  (in_ch.sample_value),
    .in_known  (in_ch.value_known),
    .push      (push),
    .push_rec  (push_rec)
  );

  ffta_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (push_rec),
    .not_full  (q_not_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .head      (q_head)
  );

  ffta_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_not_empty),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_expected (out_ch.expected_ticks),
    .out_known    (out_ch.known_ticks),
    .out_full     (out_ch.full_ticks),
    .out_occ_w    (out_ch.occupancy_weighted),
    .out_cap_w    (out_ch.capacity_weighted)
  );

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FIFO full-time accumulator. Occupancy and
// capacity change beats are queued and driven over the event channel. An
// internal tracker mirrors the occupancy, capacity and window state and
// builds the totals each finish beat should produce. Report beats are checked
// field by field in order. The run covers several window and width settings,
// idle and stall patterns on both channels, and one long report hold-off.
// ----------------------------------------------------------------------------
module testbench
  import ffta_pkg::*;
();

  localparam logic [1:0]       ACT_UNUSED   = 2'd3;
  localparam logic [REG_W-1:0] TICK_MAX     = {REG_W{1'b1}};
  localparam int               IDLE_LIMIT   = 4000;
  localparam int               HOLD_CYCLES  = 400;
  localparam int               DRAIN_CYCLES = 12;

  typedef struct {
    logic [1:0]       action;
    logic [REG_W-1:0] tick;
    logic [VAL_W-1:0] value;
    logic             known;
  } ev_beat_t;

  typedef struct {
    logic [REG_W-1:0] expected;
    logic [SUM_W-1:0] known;
    logic [SUM_W-1:0] full;
    logic [SUM_W-1:0] occ_w;
    logic [SUM_W-1:0] cap_w;
  } totals_t;

  logic              clk   = 1'b0;
  logic              rst_n = 1'b0;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  ffta_in_if #(.TIME_WIDTH(REG_W)) ev_if ();
  ffta_out_if                      tot_if ();

  fifo_full_time_accumulator_unit u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (ev_if),
    .out_ch  (tot_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // pending event beats and totals still owed
  ev_beat_t event_q[$];
  totals_t  totals_due[$];

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int errors       = 0;
  int stuck        = 0;
  int hold_left    = 0;
  logic hold_go    = 1'b0;
  logic hold_used  = 1'b0;

  // register copy
  logic [REG_W-1:0]  cfg_win_start = '0;
  logic [REG_W-1:0]  cfg_win_end   = TICK_MAX;
  logic [BITS_W-1:0] cfg_occ_bits  = 6'd32;
  logic [BITS_W-1:0] cfg_cap_bits  = 6'd32;

  // tracked monitor state
  logic [VAL_W-1:0] occ_level   = '0;
  logic             occ_known   = 1'b0;
  logic [VAL_W-1:0] cap_level   = '0;
  logic             cap_known   = 1'b0;
  logic             any_seen    = 1'b0;
  logic [REG_W-1:0] first_tick  = '0;
  logic [REG_W-1:0] last_tick   = '0;
  logic [SUM_W-1:0] known_total = '0;
  logic [SUM_W-1:0] full_total  = '0;
  logic [SUM_W-1:0] occ_total   = '0;
  logic [SUM_W-1:0] cap_total   = '0;

  function automatic logic [SUM_W-1:0] add_clamped(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] scale_clamped(input logic [VAL_W-1:0] v,
                                                     input logic [SUM_W-1:0] t);
    logic [SUM_W+VAL_W-1:0] p;
    p = {{SUM_W{1'b0}}, v} * {{VAL_W{1'b0}}, t};
    return (p[SUM_W+VAL_W-1:SUM_W] != 0) ? {SUM_W{1'b1}} : p[SUM_W-1:0];
  endfunction

  // width register to value mask; 0 acts as 1, anything above 32 as 32
  function automatic logic [VAL_W-1:0] width_mask(input logic [BITS_W-1:0] bits);
    if (bits == 0) return 32'h1;
    if (bits >= VAL_W) return {VAL_W{1'b1}};
    return (32'h1 << bits) - 32'h1;
  endfunction

  // fold one accepted beat into the tracked state
  task automatic account_beat(input ev_beat_t b);
    logic [REG_W-1:0] lo;
    logic [REG_W-1:0] hi;
    logic [SUM_W-1:0] ticks;
    totals_t          r;
    if (b.action == ACT_FIN) begin
      r.expected = '0;
      if (any_seen) begin
        lo = (cfg_win_start > first_tick) ? cfg_win_start : first_tick;
        hi = (cfg_win_end < last_tick) ? cfg_win_end : last_tick;
        if (hi > lo) r.expected = hi - lo;
      end
      r.known = known_total;
      r.full  = full_total;
      r.occ_w = occ_total;
      r.cap_w = cap_total;
      totals_due.insert(totals_due.size(), r);
      occ_level   = '0;
      occ_known   = 1'b0;
      cap_level   = '0;
      cap_known   = 1'b0;
      any_seen    = 1'b0;
      first_tick  = '0;
      last_tick   = '0;
      known_total = '0;
      full_total  = '0;
      occ_total   = '0;
      cap_total   = '0;
    end else if (b.action != ACT_UNUSED) begin
      // credit the interval with the values held before this change
      if (any_seen && b.tick > last_tick) begin
        lo = (last_tick > cfg_win_start) ? last_tick : cfg_win_start;
        hi = (b.tick < cfg_win_end) ? b.tick : cfg_win_end;
        if (hi > lo && occ_known && cap_known && cap_level != 0) begin
          ticks       = {{(SUM_W-REG_W){1'b0}}, hi - lo};
          known_total = add_clamped(known_total, ticks);
          occ_total   = add_clamped(occ_total, scale_clamped(occ_level, ticks));
          cap_total   = add_clamped(cap_total, scale_clamped(cap_level, ticks));
          if (occ_level >= cap_level) full_total = add_clamped(full_total, ticks);
        end
      end
      if (!any_seen) begin
        first_tick = b.tick;
        last_tick  = b.tick;
        any_seen   = 1'b1;
      end else begin
        if (b.tick < first_tick) first_tick = b.tick;
        if (b.tick > last_tick) last_tick = b.tick;
      end
      if (b.action == ACT_OCC) begin
        occ_known = b.known;
        occ_level = b.known ? (b.value & width_mask(cfg_occ_bits)) : '0;
      end else begin
        cap_known = b.known;
        cap_level = b.known ? (b.value & width_mask(cfg_cap_bits)) : '0;
      end
    end
  endtask

  task automatic note_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [SUM_W-1:0] got,
                             input logic [SUM_W-1:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // event channel driver
  always @(posedge clk) begin : drive_events
    logic take_next;
    if (!rst_n) begin
      ev_if.valid        <= 1'b0;
      ev_if.action       <= ACT_OCC;
      ev_if.event_time   <= '0;
      ev_if.sample_value <= '0;
      ev_if.value_known  <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) account_beat(event_q.pop_front());
      take_next = !ev_if.valid || ev_if.ready;
      if (take_next) begin
        if (event_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          ev_if.valid        <= 1'b1;
          ev_if.action       <= event_q[0].action;
          ev_if.event_time   <= event_q[0].tick;
          ev_if.sample_value <= event_q[0].value;
          ev_if.value_known  <= event_q[0].known;
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  // report channel monitor
  always @(posedge clk) begin : check_totals
    totals_t want;
    if (!rst_n) begin
      tot_if.ready <= 1'b0;
    end else begin
      if (tot_if.valid && tot_if.ready) begin
        if (totals_due.size() == 0) begin
          note_mismatch("report beat with no finish outstanding");
        end else begin
          want = totals_due.pop_front();
          check_field("expected_ticks", {16'd0, tot_if.expected_ticks}, {16'd0, want.expected});
          check_field("known_ticks", tot_if.known_ticks, want.known);
          check_field("full_ticks", tot_if.full_ticks, want.full);
          check_field("occupancy_weighted", tot_if.occupancy_weighted, want.occ_w);
          check_field("capacity_weighted", tot_if.capacity_weighted, want.cap_w);
        end
      end
      tot_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // one long report hold-off so the record queue backs up into the input
  always @(posedge clk) begin : hold_off
    if (!rst_n) begin
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // no beat on either channel for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (ev_if.valid && ev_if.ready) || (tot_if.valid && tot_if.ready)) begin
      stuck <= 0;
    end else if (stuck >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_WIN_START: cfg_win_start = data[REG_W-1:0];
      REG_WIN_END:   cfg_win_end   = data[REG_W-1:0];
      REG_OCC_BITS:  cfg_occ_bits  = data[BITS_W-1:0];
      REG_CAP_BITS:  cfg_cap_bits  = data[BITS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_beat(input logic [1:0] action, input logic [REG_W-1:0] tick,
                            input logic [VAL_W-1:0] value, input logic known);
    ev_beat_t b;
    b.action = action;
    b.tick   = tick;
    b.value  = value;
    b.known  = known;
    event_q.insert(event_q.size(), b);
  endtask

  // start tick of a sequence: mostly low, some anywhere, some near the top
  function automatic logic [REG_W-1:0] base_tick();
    logic [63:0] x;
    int          r;
    r = $urandom_range(0, 99);
    x = {$urandom, $urandom};
    if (r < 60) return REG_W'($urandom_range(0, 300000));
    if (r < 80) return x[REG_W-1:0];
    return TICK_MAX - REG_W'($urandom_range(0, 24'hFF_FFFF));
  endfunction

  // next tick: mostly forward, sometimes equal, backwards or a big jump
  function automatic logic [REG_W-1:0] step_tick(input logic [REG_W-1:0] t);
    logic [SUM_W-1:0] nt;
    int               r;
    r  = $urandom_range(0, 99);
    nt = {16'd0, t};
    if (r < 5) nt = nt;
    else if (r < 10) nt = (nt > 3000) ? nt - SUM_W'($urandom_range(1, 3000)) : '0;
    else if (r < 15) nt = nt + ({32'd0, $urandom} << $urandom_range(0, 8));
    else if (r < 30) nt = nt + SUM_W'($urandom_range(0, 50000));
    else nt = nt + SUM_W'($urandom_range(1, 2000));
    return (nt > {16'd0, TICK_MAX}) ? TICK_MAX : nt[REG_W-1:0];
  endfunction

  // well-formed change sequences closed by a finish, with some noise mixed in
  task automatic gen_items(input int count);
    int               made;
    int               len;
    int               r;
    logic [1:0]       act;
    logic [REG_W-1:0] t;
    logic [VAL_W-1:0] value;
    logic [VAL_W-1:0] cap_hint;
    made = 0;
    while (made < count) begin
      t        = base_tick();
      len      = $urandom_range(1, 30);
      cap_hint = 8;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 4) act = ACT_UNUSED;
        else if (r < 6) act = ACT_FIN;
        else if (i == 0 || r < 32) act = ACT_CAP;
        else act = ACT_OCC;
        r = $urandom_range(0, 99);
        if (act == ACT_CAP) begin
          if (r < 5) value = '0;
          else if (r < 70) value = $urandom_range(1, 64);
          else if (r < 85) value = $urandom_range(1, 255);
          else value = $urandom;
          cap_hint = value;
        end else begin
          if (r < 50) value = (cap_hint > 1000) ? $urandom : $urandom_range(0, cap_hint + 3);
          else if (r < 80) value = $urandom_range(0, 64);
          else value = $urandom;
        end
        t = step_tick(t);
        queue_beat(act, t, value, $urandom_range(0, 99) < 92);
        if (act != ACT_UNUSED) made++;
      end
      queue_beat(ACT_FIN, base_tick(), $urandom, $urandom_range(0, 1) != 0);
      made++;
    end
  endtask

  // sender holds off until every report is back, plus pipeline drain
  task automatic settle();
    while (event_q.size() != 0 || totals_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int count, input int tx, input int rx);
    tx_idle_pct  <= tx;
    rx_stall_pct <= rx;
    gen_items(count);
    settle();
  endtask

  initial begin : stimulus
    logic [REG_W-1:0] ws;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty finish, ordering corner cases, unknowns, saturation
    queue_beat(ACT_FIN, 48'd7, 32'h1234, 1'b1);
    queue_beat(ACT_CAP, 48'd100, 32'd8, 1'b1);
    queue_beat(ACT_OCC, 48'd110, 32'd3, 1'b1);
    queue_beat(ACT_OCC, 48'd150, 32'd8, 1'b1);
    queue_beat(ACT_OCC, 48'd120, 32'd2, 1'b1);      // tick goes backwards
    queue_beat(ACT_OCC, 48'd150, 32'd9, 1'b1);      // same tick as last
    queue_beat(ACT_CAP, 48'd200, 32'd0, 1'b0);      // capacity turns unknown
    queue_beat(ACT_OCC, 48'd250, 32'd5, 1'b1);
    queue_beat(ACT_CAP, 48'd260, 32'd0, 1'b1);      // zero capacity
    queue_beat(ACT_OCC, 48'd300, 32'hFFFF_FFFF, 1'b0);
    queue_beat(ACT_UNUSED, 48'd5, 32'hFFFF_FFFF, 1'b1);
    queue_beat(ACT_CAP, 48'd90, 32'hFFFF_FFFF, 1'b1); // lowers first tick
    queue_beat(ACT_OCC, 48'd400, 32'hFFFF_FFFF, 1'b1);
    queue_beat(ACT_FIN, TICK_MAX, 32'hFFFF_FFFF, 1'b0);
    queue_beat(ACT_CAP, 48'd0, 32'hFFFF_FFFF, 1'b1);
    queue_beat(ACT_OCC, 48'd0, 32'hFFFF_FFFF, 1'b1);
    queue_beat(ACT_OCC, TICK_MAX, 32'd0, 1'b1);       // products saturate
    queue_beat(ACT_CAP, TICK_MAX, 32'd1, 1'b1);
    queue_beat(ACT_OCC, TICK_MAX, 32'd1, 1'b1);
    queue_beat(ACT_FIN, 48'd0, 32'd0, 1'b0);
    queue_beat(ACT_FIN, 48'd0, 32'd0, 1'b0);
    settle();

    // narrow window, 8-bit values, no idling
    cfg_write(REG_WIN_START, 64'd1000);
    cfg_write(REG_WIN_END, 64'd150000);
    cfg_write(REG_OCC_BITS, 64'd8);
    cfg_write(REG_CAP_BITS, 64'd8);
    run_phase(200, 0, 0);

    // full window, width zero and oversize, sender idling
    cfg_write(REG_WIN_START, 64'd0);
    cfg_write(REG_WIN_END, {16'd0, TICK_MAX});
    cfg_write(REG_OCC_BITS, 64'd0);
    cfg_write(REG_CAP_BITS, 64'd63);
    run_phase(200, 64, 0);

    // empty window, one-bit values, receiver stalling
    cfg_write(REG_WIN_START, 64'd50000);
    cfg_write(REG_WIN_END, 64'd50000);
    cfg_write(REG_OCC_BITS, 64'd1);
    cfg_write(REG_CAP_BITS, 64'd1);
    run_phase(200, 0, 64);

    // inverted window, both sides idling
    cfg_write(REG_WIN_START, {16'd0, TICK_MAX});
    cfg_write(REG_WIN_END, 64'd0);
    cfg_write(REG_OCC_BITS, 64'd32);
    cfg_write(REG_CAP_BITS, 64'd16);
    run_phase(200, 37, 37);

    // random low window with the long report hold-off
    ws = REG_W'($urandom_range(0, 100000));
    cfg_write(REG_WIN_START, {16'd0, ws});
    cfg_write(REG_WIN_END, {16'd0, ws + REG_W'($urandom_range(1, 200000))});
    cfg_write(REG_OCC_BITS, APB_DW'($urandom_range(1, 32)));
    cfg_write(REG_CAP_BITS, APB_DW'($urandom_range(1, 32)));
    hold_go <= 1'b1;
    run_phase(200, 0, 0);

    // window at the top of the tick range
    cfg_write(REG_WIN_START, {16'd0, TICK_MAX - 48'h80_0000});
    cfg_write(REG_WIN_END, {16'd0, TICK_MAX});
    cfg_write(REG_OCC_BITS, 64'd32);
    cfg_write(REG_CAP_BITS, 64'd32);
    run_phase(200, 37, 37);

    // random data with junk in the unused upper bits
    cfg_write(REG_WIN_START, {$urandom, $urandom});
    cfg_write(REG_WIN_END, {$urandom, $urandom});
    cfg_write(REG_OCC_BITS, {$urandom, $urandom});
    cfg_write(REG_CAP_BITS, {$urandom, $urandom});
    run_phase(200, 64, 0);

    cfg_write(REG_WIN_START, 64'd0);
    cfg_write(REG_WIN_END, 64'd200000);
    cfg_write(REG_OCC_BITS, APB_DW'($urandom_range(0, 63)));
    cfg_write(REG_CAP_BITS, APB_DW'($urandom_range(0, 63)));
    run_phase(200, 0, 64);

    if (errors == 0 && totals_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
